FILE: design/mdio_pkg.sv
`default_nettype none

package mdio_pkg;

    localparam int MDIO_DIVISOR_BITS_DEFAULT = 8;

    localparam int S_TDATA_WIDTH = 24;
    localparam int S_TUSER_WIDTH = 3;
    localparam int M_TDATA_WIDTH = 24;
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_WRITE = 2'd1,
        ACT_READ  = 2'd2
    } action_t;

    localparam logic SEL_CONTROL = 1'b0;
    localparam logic SEL_DATA    = 1'b1;

    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // Register index as seen in paddr[2].
    localparam logic REG_CLOCK_DIVISOR = 1'b0;

    localparam logic [5:0] PREAMBLE_END = 6'd32;
    localparam logic [5:0] START_ZERO   = 6'd32;
    localparam logic [5:0] START_ONE    = 6'd33;
    localparam logic [5:0] OP_HIGH      = 6'd34;
    localparam logic [5:0] OP_LOW       = 6'd35;
    localparam logic [5:0] PHY_LAST     = 6'd40;
    localparam logic [5:0] REG_LAST     = 6'd45;
    localparam logic [5:0] TA_FIRST     = 6'd46;
    localparam logic [5:0] TA_SECOND    = 6'd47;
    localparam logic [5:0] DATA_FIRST   = 6'd48;
    localparam logic [5:0] FRAME_LAST   = 6'd63;

    localparam int RESULT_WIDTH = 19;

    typedef struct packed {
        logic [15:0] read_data;
        logic        mdio_drive;
        logic        mdio_out;
        logic        mdc;
    } result_t;

    // Returns {drive, level} for the given frame position.
    function automatic logic [1:0] pin_level(
        input logic        busy,
        input logic [5:0]  fb,
        input logic [11:0] cmd,
        input logic [15:0] dw
    );
        logic [1:0] op;
        logic [4:0] phy;
        logic [4:0] rg;
        logic [1:0] res;
        op  = cmd[11:10];
        phy = cmd[9:5];
        rg  = cmd[4:0];
        if (!busy) begin
            res = 2'b00;
        end else if (fb < PREAMBLE_END) begin
            res = 2'b11;
        end else if (fb == START_ZERO) begin
            res = 2'b10;
        end else if (fb == START_ONE) begin
            res = 2'b11;
        end else if (fb == OP_HIGH) begin
            res = {1'b1, op[1]};
        end else if (fb == OP_LOW) begin
            res = {1'b1, op[0]};
        end else if (fb <= PHY_LAST) begin
            res = {1'b1, phy[3'(PHY_LAST - fb)]};
        end else if (fb <= REG_LAST) begin
            res = {1'b1, rg[3'(REG_LAST - fb)]};
        end else if (op == OP_READ) begin
            res = 2'b00;
        end else if (fb == TA_FIRST) begin
            res = 2'b11;
        end else if (fb == TA_SECOND) begin
            res = 2'b10;
        end else begin
            res = {1'b1, dw[4'(FRAME_LAST - fb)]};
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: design/mdio_management_master_core.sv
// Clause-22 MDIO management master. Each input item is either one system clock
// tick or one access to the control or data register; every accepted item
// yields exactly one result item carrying the MDC and MDIO pin levels after
// that item and, for register reads, the read value. The block accepts one
// item per cycle unless the output buffer is full; each result is registered
// in the buffer before it appears on the master side, and the two-entry buffer
// keeps the input side open while one result waits. MDC runs only during a
// frame and toggles when the tick counter reaches clock_divisor; a frame is 64
// bits. Write clock_divisor through the APB port only while no frame is running.
`default_nettype none

module mdio_management_master_core #(
    parameter int DIVISOR_BITS = mdio_pkg::MDIO_DIVISOR_BITS_DEFAULT
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    // write_data [15:0], mdio_in [16], zero padding [23:17]
    input  wire logic [mdio_pkg::S_TDATA_WIDTH-1:0]  s_tdata,
    // action [1:0], reg_select [2]
    input  wire logic [mdio_pkg::S_TUSER_WIDTH-1:0]  s_tuser,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // mdc [0], mdio_out [1], mdio_drive [2], read_data [18:3], zero padding [23:19]
    output logic      [mdio_pkg::M_TDATA_WIDTH-1:0]  m_tdata,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [mdio_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  wire logic [mdio_pkg::APB_DATA_WIDTH-1:0] pwdata,
    output logic      [mdio_pkg::APB_DATA_WIDTH-1:0] prdata,
    output logic                                     pready
);
    import mdio_pkg::*;

    logic [DIVISOR_BITS-1:0] divisor;
    logic                    accept;
    result_t                 result;
    result_t                 out_result;

    mdio_apb_regs #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .divisor (divisor)
    );

    assign accept = s_tvalid && s_tready;

    mdio_frame_engine #(
        .DIVISOR_BITS (DIVISOR_BITS)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .action     (s_tuser[1:0]),
        .reg_select (s_tuser[2]),
        .write_data (s_tdata[15:0]),
        .mdio_in    (s_tdata[16]),
        .divisor    (divisor),
        .result     (result)
    );

    mdio_out_buffer u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_result)
    );

    assign m_tdata = {(M_TDATA_WIDTH - RESULT_WIDTH)'(0), out_result};

endmodule

`default_nettype wire

FILE: design/mdio_apb_regs.sv
`default_nettype none

module mdio_apb_regs #(
    parameter int DIVISOR_BITS = mdio_pkg::MDIO_DIVISOR_BITS_DEFAULT
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [mdio_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  wire logic [mdio_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic      [mdio_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                       pready,
    output logic      [DIVISOR_BITS-1:0]               divisor
);
    import mdio_pkg::*;

    logic [DIVISOR_BITS-1:0] divisor_reg;
    logic [DIVISOR_BITS-1:0] divisor_next;
    logic                    wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready
                    && (paddr[2] == REG_CLOCK_DIVISOR);

    // Only the low byte is defined; it is then cut or extended to the counter width.
    assign divisor_next = DIVISOR_BITS'(pwdata[7:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            divisor_reg <= '0;
        end else if (wr_en) begin
            divisor_reg <= divisor_next;
        end
    end

    always_comb begin
        if (paddr[2] == REG_CLOCK_DIVISOR) begin
            prdata = APB_DATA_WIDTH'(divisor_reg);
        end else begin
            prdata = '0;
        end
    end

    assign divisor = divisor_reg;

endmodule

`default_nettype wire

FILE: design/mdio_frame_engine.sv
`default_nettype none

module mdio_frame_engine #(
    parameter int DIVISOR_BITS = mdio_pkg::MDIO_DIVISOR_BITS_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     accept,
    input  wire logic [1:0]               action,
    input  wire logic                     reg_select,
    input  wire logic [15:0]              write_data,
    input  wire logic                     mdio_in,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output mdio_pkg::result_t             result
);
    import mdio_pkg::*;

    logic [DIVISOR_BITS-1:0] tick_reg,  tick_next;
    logic                    level_reg, level_next;
    logic [5:0]              bit_reg,   bit_next;
    logic                    busy_reg,  busy_next;
    logic                    error_reg, error_next;
    logic [11:0]             cmd_reg,   cmd_next;
    logic [15:0]             data_reg,  data_next;
    logic [15:0]             rdata;
    logic [1:0]              pin;
    action_t                 act;

    assign act = action_t'(action);

    always_comb begin
        tick_next  = tick_reg;
        level_next = level_reg;
        bit_next   = bit_reg;
        busy_next  = busy_reg;
        error_next = error_reg;
        cmd_next   = cmd_reg;
        data_next  = data_reg;
        rdata      = '0;
        case (act)
            ACT_TICK: begin
                if (!busy_reg) begin
                    tick_next  = '0;
                    level_next = 1'b0;
                end else if (tick_reg >= divisor) begin
                    tick_next = '0;
                    if (!level_reg) begin
                        // Rising MDC edge: sample the PHY on read frames.
                        level_next = 1'b1;
                        if (cmd_reg[11:10] == OP_READ) begin
                            if (bit_reg == TA_SECOND && mdio_in) begin
                                error_next = 1'b1;
                            end else if (bit_reg >= DATA_FIRST) begin
                                data_next = {data_reg[14:0], mdio_in};
                            end
                        end
                    end else begin
                        level_next = 1'b0;
                        if (bit_reg == FRAME_LAST) begin
                            bit_next  = '0;
                            busy_next = 1'b0;
                        end else begin
                            bit_next = bit_reg + 6'd1;
                        end
                    end
                end else begin
                    tick_next = tick_reg + 1'b1;
                end
            end
            ACT_WRITE: begin
                if (!busy_reg) begin
                    if (reg_select == SEL_DATA) begin
                        data_next = write_data;
                    end else begin
                        cmd_next = write_data[11:0];
                        if (write_data[11:10] == OP_WRITE || write_data[11:10] == OP_READ) begin
                            busy_next  = 1'b1;
                            error_next = 1'b0;
                            bit_next   = '0;
                            tick_next  = '0;
                            level_next = 1'b0;
                        end
                    end
                end
            end
            ACT_READ: begin
                if (reg_select == SEL_DATA) begin
                    rdata = data_reg;
                end else begin
                    rdata = {busy_reg, error_reg, 2'b00, cmd_reg};
                end
            end
            default: begin
            end
        endcase
    end

    assign pin = pin_level(busy_next, bit_next, cmd_next, data_next);

    always_comb begin
        result.read_data  = rdata;
        result.mdio_drive = pin[1];
        result.mdio_out   = pin[0];
        result.mdc        = level_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg  <= '0;
            level_reg <= 1'b0;
            bit_reg   <= '0;
            busy_reg  <= 1'b0;
            error_reg <= 1'b0;
            cmd_reg   <= '0;
            data_reg  <= '0;
        end else if (accept) begin
            tick_reg  <= tick_next;
            level_reg <= level_next;
            bit_reg   <= bit_next;
            busy_reg  <= busy_next;
            error_reg <= error_next;
            cmd_reg   <= cmd_next;
            data_reg  <= data_next;
        end
    end

endmodule

`default_nettype wire

FILE: design/mdio_out_buffer.sv
`default_nettype none

module mdio_out_buffer (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mdio_pkg::result_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mdio_pkg::result_t       out_data
);
    import mdio_pkg::*;

    logic    main_valid_reg;
    logic    skid_valid_reg;
    result_t main_data_reg;
    result_t skid_data_reg;
    logic    push;
    logic    pop;

    assign in_ready  = !skid_valid_reg;
    assign push      = in_valid && in_ready;
    assign pop       = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_valid_reg <= 1'b1;
        end else if (push) begin
            main_valid_reg <= 1'b1;
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (push && main_valid_reg && !pop) begin
            skid_data_reg <= in_data;
        end else if (push) begin
            main_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: design/mdio_checker.sv
`default_nettype none

module mdio_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [23:0] m_tdata,
    input wire logic        pready
);

    // A result that is still waiting must not change.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // A released MDIO line is always reported as zero.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[1] && !m_tdata[2]))
        else $error("mdio_out set while MDIO is released");

    // Reset empties the output buffer.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result item present after reset");

    // The configuration port never inserts wait states.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("pready dropped");

endmodule

bind mdio_management_master_core mdio_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .pready   (pready)
);

`default_nettype wire
